/* hw/rtl/admission_ratio_hill_climber_defines.svh */
// ----------------------------------------------------------------------------
// Admission ratio hill climber assertion macros
// Shared concurrent assertion forms for the hill climber RTL.
// ----------------------------------------------------------------------------
`ifndef ADMISSION_RATIO_HILL_CLIMBER_DEFINES_SVH
`define ADMISSION_RATIO_HILL_CLIMBER_DEFINES_SVH

// Same-cycle implication, disabled during reset.
`define ARHC_ASSERT_NOW(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled during reset.
`define ARHC_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

/* hw/rtl/arhc_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// arhc_pkg
// Types, codes and constants shared by the admission ratio hill climber.
// ----------------------------------------------------------------------------
package arhc_pkg;

  localparam int RATIO_W = 17;
  localparam int SAMPLE_W = 16;
  localparam int SCORE_W = 18;

  localparam logic [RATIO_W-1:0] Q_ONE = 17'h10000;
  localparam logic signed [SCORE_W-1:0] MINUS_ONE = -18'sd65536;

  // Register indexes of the configuration port.
  localparam logic REG_RATIO_STEP = 1'b0;
  localparam logic REG_STAB_MARGIN = 1'b1;

  localparam logic [RATIO_W-1:0] RATIO_STEP_RESET = 17'd6554;
  localparam logic [SAMPLE_W-1:0] STAB_MARGIN_RESET = 16'd655;

  // Phase codes as seen on the phase output.
  localparam logic [2:0] PC_FILL = 3'd0;
  localparam logic [2:0] PC_SETTLE = 3'd1;
  localparam logic [2:0] PC_BASE = 3'd2;
  localparam logic [2:0] PC_DOWN = 3'd3;
  localparam logic [2:0] PC_UP = 3'd4;

  typedef enum logic [4:0] {
    PH_FILL   = 5'b00001,
    PH_SETTLE = 5'b00010,
    PH_BASE   = 5'b00100,
    PH_DOWN   = 5'b01000,
    PH_UP     = 5'b10000
  } phase_t;

  typedef struct packed {
    logic [RATIO_W-1:0]  ratio_step;
    logic [SAMPLE_W-1:0] stability_margin;
  } cfg_t;

  typedef struct packed {
    logic                cache_full;
    logic [SAMPLE_W-1:0] hit_rate_sample;
    logic [SAMPLE_W-1:0] perf_sample;
  } item_t;

  typedef struct packed {
    logic [2:0]         phase;
    logic [RATIO_W-1:0] admit_ratio;
    logic               replace_enable;
    logic               clear_stats;
  } result_t;

  function automatic logic [2:0] phase_code(input phase_t ph);
    logic [2:0] code;
    code = PC_FILL;
    case (ph)
      PH_FILL:   code = PC_FILL;
      PH_SETTLE: code = PC_SETTLE;
      PH_BASE:   code = PC_BASE;
      PH_DOWN:   code = PC_DOWN;
      PH_UP:     code = PC_UP;
      default:   code = PC_FILL;
    endcase
    return code;
  endfunction

endpackage

/* hw/rtl/arhc_ctrl.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// arhc_ctrl
// Hill-climbing controller state and its one-request update.
// ----------------------------------------------------------------------------
module arhc_ctrl (
  input  logic              clk,
  input  logic              rst,
  input  logic              step_en,
  input  arhc_pkg::cfg_t    cfg,
  input  arhc_pkg::item_t   item,
  output arhc_pkg::result_t result
);

  arhc_pkg::phase_t phase, phase_next;
  logic [arhc_pkg::RATIO_W-1:0] ratio, ratio_next;
  logic replace, replace_next;
  logic signed [arhc_pkg::SCORE_W-1:0] prev_hit_rate, prev_hit_rate_next;
  logic [arhc_pkg::RATIO_W-1:0] base_ratio, base_ratio_next;
  logic [arhc_pkg::RATIO_W-1:0] down_ratio, down_ratio_next;
  logic [arhc_pkg::RATIO_W-1:0] up_ratio, up_ratio_next;
  logic [arhc_pkg::SAMPLE_W-1:0] base_score, base_score_next;
  logic signed [arhc_pkg::SCORE_W-1:0] down_score, down_score_next;
  logic clear;

  logic signed [arhc_pkg::SCORE_W-1:0] hit_diff;
  logic [arhc_pkg::SCORE_W-1:0] hit_dist;
  logic stable;
  logic step_fits;
  logic [arhc_pkg::RATIO_W-1:0] cand_down;
  logic [arhc_pkg::SCORE_W-1:0] up_sum;
  logic [arhc_pkg::RATIO_W-1:0] cand_up;
  logic down_wins;
  logic up_wins;

  // The hit-rate difference is taken at 18 bits, so it never wraps.
  assign hit_diff = $signed({2'b00, item.hit_rate_sample}) - prev_hit_rate;
  assign hit_dist = hit_diff[arhc_pkg::SCORE_W-1] ? 18'(-hit_diff) : 18'(hit_diff);
  assign stable = hit_dist < {2'b00, cfg.stability_margin};

  assign step_fits = ratio > cfg.ratio_step;
  assign cand_down = step_fits ? (ratio - cfg.ratio_step) : '0;
  assign up_sum = {1'b0, ratio} + {1'b0, cfg.ratio_step};
  assign cand_up = (up_sum > {1'b0, arhc_pkg::Q_ONE}) ? arhc_pkg::Q_ONE
                                                      : up_sum[arhc_pkg::RATIO_W-1:0];

  // Ties go to the minus step first, then to the plus step.
  assign down_wins = (down_score >= $signed({2'b00, base_score})) &&
                     (down_score >= $signed({2'b00, item.perf_sample}));
  assign up_wins = item.perf_sample >= base_score;

  always_comb begin
    phase_next = phase;
    ratio_next = ratio;
    replace_next = replace;
    prev_hit_rate_next = prev_hit_rate;
    base_ratio_next = base_ratio;
    down_ratio_next = down_ratio;
    up_ratio_next = up_ratio;
    base_score_next = base_score;
    down_score_next = down_score;
    clear = 1'b0;
    if (!item.cache_full) begin
      phase_next = arhc_pkg::PH_FILL;
    end else begin
      unique case (phase)
        arhc_pkg::PH_SETTLE: begin
          ratio_next = arhc_pkg::Q_ONE;
          prev_hit_rate_next = $signed({2'b00, item.hit_rate_sample});
          if (stable) begin
            phase_next = arhc_pkg::PH_BASE;
            replace_next = 1'b0;
          end else begin
            replace_next = 1'b1;
            clear = 1'b1;
            base_ratio_next = arhc_pkg::Q_ONE;
          end
        end
        arhc_pkg::PH_BASE: begin
          base_score_next = item.perf_sample;
          base_ratio_next = ratio;
          down_ratio_next = cand_down;
          up_ratio_next = cand_up;
          clear = 1'b1;
          if (!step_fits) begin
            down_score_next = arhc_pkg::MINUS_ONE;
            ratio_next = cand_up;
            phase_next = arhc_pkg::PH_UP;
          end else begin
            ratio_next = cand_down;
            phase_next = arhc_pkg::PH_DOWN;
          end
        end
        arhc_pkg::PH_DOWN: begin
          down_score_next = $signed({2'b00, item.perf_sample});
          ratio_next = up_ratio;
          phase_next = arhc_pkg::PH_UP;
          clear = 1'b1;
        end
        arhc_pkg::PH_UP: begin
          clear = 1'b1;
          if (down_wins) begin
            ratio_next = down_ratio;
          end else if (up_wins) begin
            ratio_next = up_ratio;
          end else begin
            ratio_next = base_ratio;
          end
          // The current ratio kept at 1.0 goes back to settling directly.
          if (!down_wins && !up_wins && base_ratio == arhc_pkg::Q_ONE) begin
            phase_next = arhc_pkg::PH_SETTLE;
          end else begin
            phase_next = stable ? arhc_pkg::PH_SETTLE : arhc_pkg::PH_BASE;
          end
        end
        default: begin
          phase_next = arhc_pkg::PH_SETTLE;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase <= arhc_pkg::PH_FILL;
      ratio <= arhc_pkg::Q_ONE;
      replace <= 1'b1;
      prev_hit_rate <= arhc_pkg::MINUS_ONE;
      base_ratio <= '0;
      down_ratio <= '0;
      up_ratio <= '0;
      base_score <= '0;
      down_score <= '0;
    end else if (step_en) begin
      phase <= phase_next;
      ratio <= ratio_next;
      replace <= replace_next;
      prev_hit_rate <= prev_hit_rate_next;
      base_ratio <= base_ratio_next;
      down_ratio <= down_ratio_next;
      up_ratio <= up_ratio_next;
      base_score <= base_score_next;
      down_score <= down_score_next;
    end
  end

  assign result.phase = arhc_pkg::phase_code(phase_next);
  assign result.admit_ratio = ratio_next;
  assign result.replace_enable = replace_next;
  assign result.clear_stats = clear;

endmodule

/* hw/rtl/admission_ratio_hill_climber.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// admission_ratio_hill_climber
// Tunes a cache load-admission ratio from one measurement per timer tick.
// ----------------------------------------------------------------------------
// Each accepted request (one tick's measurement) yields exactly one result.
// The block takes one request per clock cycle while in_stall is low. The
// request waits in the input register; as it advances, the controller state
// is updated and the result is written into the output register, which
// drives the outputs. A stalled result holds the input register, and the
// input stalls only while both registers are full and the result is
// stalled. Configuration writes take effect on the next tick processed.
`include "admission_ratio_hill_climber_defines.svh"

module admission_ratio_hill_climber (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           cfg_we,
  input  logic                           cfg_index,
  input  logic [arhc_pkg::RATIO_W-1:0]   cfg_wdata,
  input  logic                           in_valid,
  output logic                           in_stall,
  input  logic                           cache_full,
  input  logic [arhc_pkg::SAMPLE_W-1:0]  hit_rate_sample,
  input  logic [arhc_pkg::SAMPLE_W-1:0]  perf_sample,
  output logic                           out_valid,
  input  logic                           out_stall,
  output logic [2:0]                     phase,
  output logic [arhc_pkg::RATIO_W-1:0]   admit_ratio,
  output logic                           replace_enable,
  output logic                           clear_stats
);

  arhc_pkg::cfg_t cfg;
  arhc_pkg::item_t in_q;
  logic in_q_valid;
  arhc_pkg::result_t step_result;
  arhc_pkg::result_t out_q;
  logic out_take;
  logic advance;
  logic in_accept;
  logic scoring_out;
  logic ratio_ok;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.ratio_step <= arhc_pkg::RATIO_STEP_RESET;
      cfg.stability_margin <= arhc_pkg::STAB_MARGIN_RESET;
    end else if (cfg_we) begin
      unique case (cfg_index)
        arhc_pkg::REG_RATIO_STEP:  cfg.ratio_step <= cfg_wdata;
        arhc_pkg::REG_STAB_MARGIN: cfg.stability_margin <= cfg_wdata[arhc_pkg::SAMPLE_W-1:0];
        default: ;
      endcase
    end
  end

  assign out_take = !out_valid || !out_stall;
  assign advance = in_q_valid && out_take;
  assign in_stall = in_q_valid && !out_take;
  assign in_accept = in_valid && !in_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_q_valid <= 1'b0;
    end else if (in_accept) begin
      in_q_valid <= 1'b1;
    end else if (advance) begin
      in_q_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_accept) begin
      in_q.cache_full <= cache_full;
      in_q.hit_rate_sample <= hit_rate_sample;
      in_q.perf_sample <= perf_sample;
    end
  end

  arhc_ctrl u_ctrl (
    .clk     (clk),
    .rst     (rst),
    .step_en (advance),
    .cfg     (cfg),
    .item    (in_q),
    .result  (step_result)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      out_q <= step_result;
    end
  end

  assign phase = out_q.phase;
  assign admit_ratio = out_q.admit_ratio;
  assign replace_enable = out_q.replace_enable;
  assign clear_stats = out_q.clear_stats;

  assign scoring_out = out_valid &&
                       (phase == arhc_pkg::PC_DOWN || phase == arhc_pkg::PC_UP);
  assign ratio_ok = admit_ratio <= arhc_pkg::Q_ONE;

  // Every scoring step asks for fresh statistics.
  `ARHC_ASSERT_NOW(a_score_clears, clk, rst, scoring_out, clear_stats, "scoring without clear")
  // The ratio never leaves the range zero to one.
  `ARHC_ASSERT_NOW(a_ratio_bound, clk, rst, out_valid, ratio_ok, "admission ratio above one")
  // A held request moves to the result register as soon as it is free.
  `ARHC_ASSERT_NEXT(a_advance, clk, rst, advance, out_valid, "held request not advanced")

endmodule
